>>> hw/rtl/fe_pkg.sv
package fe_pkg;

  // Single-precision constants
  localparam logic [31:0] FE_INV_LN2  = 32'h3FB8AA3B;
  localparam logic [31:0] FE_LN2      = 32'h3F317218;
  localparam logic [31:0] FE_NEG_LN2  = 32'hBF317218;
  localparam logic [31:0] FE_HALF_LN2 = 32'h3EB17218;
  localparam logic [31:0] FE_HALF     = 32'h3F000000;
  localparam logic [31:0] FE_NEG_HALF = 32'hBF000000;
  localparam logic [31:0] FE_ONE      = 32'h3F800000;
  localparam logic [31:0] FE_C7       = 32'h39500D01;  // 1/5040
  localparam logic [31:0] FE_C6       = 32'h3AB60B61;  // 1/720
  localparam logic [31:0] FE_MAX      = 32'h7F7FFFFF;
  localparam logic [31:0] FE_QNAN     = 32'h7FC00000;
  localparam logic [30:0] FE_LOW_MAG  = 31'h42CE0000;  // 103.0
  localparam logic [30:0] FE_HIGH_MAG = 31'h42B00000;  // 88.0

  // Horner coefficients after the 1/720 step: 1/120, 1/24, 1/6, 1/2
  localparam logic [31:0] FE_HCOEF [4] = '{32'h3C088889, 32'h3D2AAAAB,
                                           32'h3E2AAAAB, 32'h3F000000};

  // Control carried alongside each request
  typedef struct packed {
    logic        valid;
    logic        spec;
    logic [31:0] spec_bits;
  } fe_side_t;

  // Normalize and round to nearest even; value is p * 2^(e - 127 - 46)
  function automatic logic [31:0] fe_round_pack(input logic s, input logic signed [10:0] e,
                                                input logic [47:0] p);
    logic [5:0]         lz;
    logic               found;
    logic signed [10:0] er;
    logic [47:0]        pn;
    logic [47:0]        ps;
    logic [47:0]        mask;
    logic [5:0]         sh;
    logic               lost;
    logic               st;
    logic               inc;
    logic [7:0]         ef;
    logic [30:0]        body;
    lz    = '0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && p[i]) begin
        lz    = 6'(47 - i);
        found = 1'b1;
      end
    end
    er = e + 11'sd1 - $signed({5'b00000, lz});
    pn = p << lz;
    sh = '0;
    if (er < 11'sd1) begin
      if (er < -11'sd46) sh = 6'd47;
      else sh = 6'(11'sd1 - er);
    end
    mask = ~({48{1'b1}} << sh);
    lost = |(pn & mask);
    ps   = pn >> sh;
    st   = lost | (|ps[22:0]);
    inc  = ps[23] & (st | ps[24]);
    ef   = (er < 11'sd1) ? 8'd0 : er[7:0];
    body = {ef, ps[46:24]} + 31'(inc);
    return {s, body};
  endfunction

  function automatic logic [31:0] fe_mul(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]         ea;
    logic [7:0]         eb;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [47:0]        p;
    logic signed [10:0] e;
    logic               s;
    logic [31:0]        res;
    s  = a[31] ^ b[31];
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    p  = ma * mb;
    e  = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
    if (p == 48'd0) res = {s, 31'd0};
    else res = fe_round_pack(s, e, p);
    return res;
  endfunction

  function automatic logic [31:0] fe_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  d;
    logic [23:0] mx;
    logic [23:0] my;
    logic [27:0] ax;
    logic [27:0] ay;
    logic [27:0] ys;
    logic [27:0] mask;
    logic        lost;
    logic [27:0] sum;
    logic [31:0] res;
    if (a[30:0] < b[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx   = {|x[30:23], x[22:0]};
    my   = {|y[30:23], y[22:0]};
    d    = ex - ey;
    ax   = {1'b0, mx, 3'b000};
    ay   = {1'b0, my, 3'b000};
    mask = ~({28{1'b1}} << d);
    lost = |(ay & mask);
    ys   = (ay >> d) | {27'd0, lost};
    sum  = (x[31] == y[31]) ? ax + ys : ax - ys;
    if (sum == 28'd0) res = {x[31] & y[31], 31'd0};
    else res = fe_round_pack(x[31], $signed({3'b000, ex}), {sum, 20'd0});
    return res;
  endfunction

  // Truncate toward zero; magnitude stays below 150
  function automatic logic signed [8:0] fe_trunc(input logic [31:0] v);
    logic [7:0]        e;
    logic [23:0]       m;
    logic [7:0]        mag;
    logic signed [8:0] n;
    e = v[30:23];
    m = {1'b1, v[22:0]};
    if (e < 8'd127) mag = '0;
    else mag = 8'(m >> (8'd150 - e));
    n = v[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    return n;
  endfunction

  function automatic logic [31:0] fe_i2f(input logic signed [8:0] n);
    logic [8:0]  mag;
    logic [31:0] res;
    mag = n[8] ? 9'(-n) : 9'(n);
    if (mag == 9'd0) res = '0;
    else res = fe_round_pack(n[8], 11'sd173, {39'd0, mag});
    return res;
  endfunction

  function automatic logic [31:0] fe_scale(input logic signed [8:0] n);
    logic [31:0] res;
    logic [8:0]  eb;
    eb = 9'(n + 9'sd127);
    if (n < -9'sd126) res = '0;
    else res = {1'b0, eb[7:0], 23'd0};
    return res;
  endfunction

endpackage

>>> hw/rtl/fe_reduce.sv
module fe_reduce import fe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  fe_side_t          side_i,
  input  logic [31:0]       x_i,
  output fe_side_t          side_o,
  output logic signed [8:0] n_o,
  output logic [31:0]       r_o
);

  fe_side_t          side1_q, side2_q, side3_q, side4_q, side5_q, side6_q;
  logic [31:0]       x1_q, x2_q, x3_q, x4_q;
  logic [31:0]       sc1_q, rnd2_q, nf3_q, nl4_q, r5_q, r6_q;
  logic signed [8:0] n3_q, n4_q, n5_q, n6_q;
  logic signed [8:0] n3_d;
  logic              gt5, lt5;
  logic [31:0]       radj5;

  assign n3_d  = fe_trunc(rnd2_q);
  assign gt5   = !r5_q[31] && (r5_q[30:0] > FE_HALF_LN2[30:0]);
  assign lt5   = r5_q[31] && (r5_q[30:0] > FE_HALF_LN2[30:0]);
  assign radj5 = fe_add(r5_q, gt5 ? FE_NEG_LN2 : FE_LN2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
      side3_q <= '0;
      side4_q <= '0;
      side5_q <= '0;
      side6_q <= '0;
    end else if (en_i) begin
      side1_q <= side_i;
      side2_q <= side1_q;
      side3_q <= side2_q;
      side4_q <= side3_q;
      side5_q <= side4_q;
      side6_q <= side5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= x_i;
      sc1_q  <= fe_mul(x_i, FE_INV_LN2);
      x2_q   <= x1_q;
      rnd2_q <= fe_add(sc1_q, (sc1_q[31] && (sc1_q[30:0] != 31'd0)) ? FE_NEG_HALF : FE_HALF);
      x3_q   <= x2_q;
      n3_q   <= n3_d;
      nf3_q  <= fe_i2f(n3_d);
      x4_q   <= x3_q;
      n4_q   <= n3_q;
      nl4_q  <= fe_mul(nf3_q, FE_LN2);
      n5_q   <= n4_q;
      r5_q   <= fe_add(x4_q, {~nl4_q[31], nl4_q[30:0]});
      // pull the remainder back within half a step of ln2
      n6_q   <= gt5 ? n5_q + 9'sd1 : (lt5 ? n5_q - 9'sd1 : n5_q);
      r6_q   <= (gt5 || lt5) ? radj5 : r5_q;
    end
  end

  assign side_o = side6_q;
  assign n_o    = n6_q;
  assign r_o    = r6_q;

endmodule

>>> hw/rtl/fe_poly.sv
module fe_poly import fe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  fe_side_t          side_i,
  input  logic signed [8:0] n_i,
  input  logic [31:0]       r_i,
  output fe_side_t          side_o,
  output logic signed [8:0] n_o,
  output logic [31:0]       p_o
);

  localparam int unsigned NCHAIN = 9;

  fe_side_t          sa_q;
  logic [31:0]       ra_q, pa_q, rra_q;
  logic signed [8:0] na_q;

  fe_side_t          cs_q  [NCHAIN];
  logic [31:0]       cr_q  [NCHAIN];
  logic [31:0]       cp_q  [NCHAIN];
  logic [31:0]       crr_q [NCHAIN];
  logic [31:0]       cu_q  [NCHAIN];
  logic signed [8:0] cn_q  [NCHAIN];

  fe_side_t          st_q, su_q;
  logic [31:0]       tt_q, tu_q, pu_q;
  logic signed [8:0] nt_q, nu_q;

  // first products and the 1/720 step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q    <= '0;
      cs_q[0] <= '0;
    end else if (en_i) begin
      sa_q    <= side_i;
      cs_q[0] <= sa_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ra_q     <= r_i;
      na_q     <= n_i;
      pa_q     <= fe_mul(r_i, FE_C7);
      rra_q    <= fe_mul(r_i, r_i);
      cr_q[0]  <= ra_q;
      cn_q[0]  <= na_q;
      crr_q[0] <= rra_q;
      cp_q[0]  <= fe_add(FE_C6, pa_q);
      cu_q[0]  <= fe_add(FE_ONE, ra_q);
    end
  end

  // alternate multiply by r and add the next coefficient
  for (genvar k = 1; k < NCHAIN; k++) begin : g_chain
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cs_q[k] <= '0;
      end else if (en_i) begin
        cs_q[k] <= cs_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cr_q[k]  <= cr_q[k-1];
        cn_q[k]  <= cn_q[k-1];
        crr_q[k] <= crr_q[k-1];
        cu_q[k]  <= cu_q[k-1];
      end
    end

    if ((k % 2) == 1) begin : g_mul
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          cp_q[k] <= fe_mul(cr_q[k-1], cp_q[k-1]);
        end
      end
    end else begin : g_add
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          cp_q[k] <= fe_add(FE_HCOEF[2'((k/2)-1)], cp_q[k-1]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
      su_q <= '0;
    end else if (en_i) begin
      st_q <= cs_q[NCHAIN-1];
      su_q <= st_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tt_q <= fe_mul(crr_q[NCHAIN-1], cp_q[NCHAIN-1]);
      tu_q <= cu_q[NCHAIN-1];
      nt_q <= cn_q[NCHAIN-1];
      pu_q <= fe_add(tu_q, tt_q);
      nu_q <= nt_q;
    end
  end

  assign side_o = su_q;
  assign n_o    = nu_q;
  assign p_o    = pu_q;

endmodule

>>> hw/rtl/float_exponential_top.sv
// An accepted request passes through fe_reduce, fe_poly and the output register to y_bits_o.
// Throughput: one request per cycle while the pipeline is not stalled.
// Stall stops the whole pipeline only while the output holds a result.
// Reset (rst_ni low, asynchronous) clears every valid bit; data is not reset.
module float_exponential_top import fe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] x_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] y_bits_o
);

  logic              en;
  fe_side_t          side_in;
  logic              is_nan, is_low, is_high;
  fe_side_t          red_side;
  logic signed [8:0] red_n;
  logic [31:0]       red_r;
  fe_side_t          poly_side;
  logic signed [8:0] poly_n;
  logic [31:0]       poly_p;
  logic              valid_q;
  logic [31:0]       y_q;

  // Advance the whole pipeline unless the output result is held
  assign en      = !(valid_q && stall_i);
  assign stall_o = !en;

  // Classify the argument up front; special results ride along with the request
  assign is_nan  = (x_bits_i[30:23] == 8'hFF) && (x_bits_i[22:0] != 23'd0);
  assign is_low  = x_bits_i[31] && (x_bits_i[30:0] >= FE_LOW_MAG);
  assign is_high = !x_bits_i[31] && (x_bits_i[30:0] >= FE_HIGH_MAG);

  always_comb begin
    side_in.valid     = valid_i;
    side_in.spec      = is_nan || is_low || is_high;
    side_in.spec_bits = is_nan ? FE_QNAN : (is_high ? FE_MAX : 32'd0);
  end

  // Range reduction: x*log2(e), round, r = x - n*ln2, correct r
  fe_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (side_in),
    .x_i    (x_bits_i),
    .side_o (red_side),
    .n_o    (red_n),
    .r_o    (red_r)
  );

  // Taylor polynomial of e^r in Horner form
  fe_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (red_side),
    .n_i    (red_n),
    .r_i    (red_r),
    .side_o (poly_side),
    .n_o    (poly_n),
    .p_o    (poly_p)
  );

  // Output stage: scale by 2^n, or take the special result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= poly_side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_q <= poly_side.spec ? poly_side.spec_bits : fe_mul(poly_p, fe_scale(poly_n));
    end
  end

  assign valid_o  = valid_q;
  assign y_bits_o = y_q;

endmodule

>>> hw/rtl/fe_chk.sv
module fe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic [31:0] x_bits_i,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] y_bits_o
);

  // hold a stalled request
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stall_o |=> valid_i && $stable(x_bits_i))
    else $error("request changed while stalled");

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(y_bits_o))
    else $error("result changed while stalled");

  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !y_bits_o[31])
    else $error("negative exponential result");

  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (y_bits_o[30:23] == 8'hFF) |-> y_bits_o == 32'h7FC00000)
    else $error("infinity or non-canonical NaN on output");

  a_nostall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("input stalled with empty output");

endmodule

bind float_exponential_top fe_chk u_fe_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .valid_i  (valid_i),
  .stall_o  (stall_o),
  .x_bits_i (x_bits_i),
  .valid_o  (valid_o),
  .stall_i  (stall_i),
  .y_bits_o (y_bits_o)
);
